/* src/sortab_pkg.sv */
// Shared types and codes for the sorted table block.
package sortab_pkg;

	// Width of one stored value.
	localparam int KEY_W = 32;

	// Request command codes.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

	// Strobes that the sequencer broadcasts to every cell of the chain.
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

/* src/sortab_cell.sv */
// One cell of the sorted chain: a stored value, its compare flags and shift logic.
module sortab_cell import sortab_pkg::*; (
	input  logic                    clk,
	input  cell_ctrl_t              ctrl,
	input  logic signed [KEY_W-1:0] key,
	input  logic                    valid,
	input  logic                    prev_le,
	input  logic                    prev_lt,
	input  logic signed [KEY_W-1:0] prev_val,
	input  logic signed [KEY_W-1:0] next_val,
	output logic signed [KEY_W-1:0] val,
	output logic                    le,
	output logic                    lt,
	output logic                    ins_hit,
	output logic                    del_hit
);

	logic signed [KEY_W-1:0] val_q;
	logic                    le_q;
	logic                    lt_q;

	// Compare against the broadcast key, then shift on insert or delete.
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			le_q <= valid && (val_q <= key);
			lt_q <= valid && (val_q < key);
		end
		if (ctrl.ins && !le_q) begin
			val_q <= prev_le ? key : prev_val;
		end else if (ctrl.del && !lt_q) begin
			val_q <= next_val;
		end
	end

	// The insert slot is the first cell not at or below the key.
	// The first equal cell is the one whose left neighbor is strictly below.
	assign ins_hit = !le_q && prev_le;
	assign del_hit = le_q && !lt_q && prev_lt;

	assign val = val_q;
	assign le  = le_q;
	assign lt  = lt_q;

endmodule

/* src/sortab_enc.sv */
// Two-level registered encoder that turns a one-hot cell flag into an index.
module sortab_enc #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic [DEPTH-1:0]         hit,
	output logic [$clog2(DEPTH)-1:0] pos,
	output logic                     found
);

	localparam int IW   = $clog2(DEPTH);
	localparam int GW   = 32;
	localparam int NGRP = (DEPTH + GW - 1) / GW;

	logic [NGRP*GW-1:0] hit_pad;
	logic [IW-1:0]      grp_pos [NGRP];
	logic               grp_any [NGRP];
	logic [IW-1:0]      grp_pos_s1 [NGRP];
	logic               grp_any_s1 [NGRP];
	logic [IW-1:0]      all_pos;
	logic               all_any;
	logic [IW-1:0]      pos_s2;
	logic               found_s2;

	assign hit_pad = (NGRP*GW)'(hit);

	// First level: each group of cells ORs the index of its flagged cell.
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		always_comb begin
			grp_pos[g] = '0;
			grp_any[g] = 1'b0;
			for (int j = 0; j < GW; j++) begin
				grp_pos[g] = grp_pos[g] | ({IW{hit_pad[g*GW+j]}} & IW'(g*GW+j));
				grp_any[g] = grp_any[g] | hit_pad[g*GW+j];
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_pos_s1 <= grp_pos;
		grp_any_s1 <= grp_any;
	end

	// Second level: merge the group results.
	always_comb begin
		all_pos = '0;
		all_any = 1'b0;
		for (int g = 0; g < NGRP; g++) begin
			all_pos = all_pos | grp_pos_s1[g];
			all_any = all_any | grp_any_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		pos_s2   <= all_pos;
		found_s2 <= all_any;
	end

	assign pos   = pos_s2;
	assign found = found_s2;

endmodule

/* src/sorted_table_insert_delete_search_top.sv */
// Top level of the sorted table: request sequencer, cell chain and result register.
//
// Keeps an ascending table of up to DEPTH signed 32-bit values in a chain of
// cells. A request (command, value) is taken on cmd_valid while cmd_stall is
// low; commands are insert, delete and search, and code 3 does nothing.
// Each request gives exactly one result (status, position, entries_held) on
// the res channel, held stable while res_stall is high.
// One request is in work at a time, so a new request is taken only once the
// last one has left its update step. A request passes the parallel compare in
// all cells, the registered index encoder, then the shift and the result
// register, in that order.
// While a finished result waits on res_stall, the next request can be taken
// and worked up to its update step, where it waits for the result register.
// Reset returns the sequencer to idle and clears the entry count and the
// result valid flag; stored values are undefined and never read beyond the count.
// Position and entries_held are reported modulo 128.
module sorted_table_insert_delete_search_top import sortab_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [1:0]        command,
	input  logic signed [31:0] value,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        status,
	output logic [6:0]        position,
	output logic [6:0]        entries_held
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (IW > 7) ? IW : 7;
	localparam int NW = (CW > 7) ? CW : 7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_ENC1,
		S_ENC2,
		S_UPD
	} state_t;

	state_t                  state_q;
	logic [1:0]              cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CW-1:0]           cnt_q;
	logic                    res_valid_q;
	logic [1:0]              status_q;
	logic [6:0]              position_q;
	logic [6:0]              held_q;

	cell_ctrl_t              ctrl;
	logic signed [KEY_W-1:0] cell_val [DEPTH];
	logic [DEPTH-1:0]        cell_valid;
	logic [DEPTH-1:0]        cell_le;
	logic [DEPTH-1:0]        cell_lt;
	logic [DEPTH-1:0]        ins_hit;
	logic [DEPTH-1:0]        del_hit;
	logic [DEPTH-1:0]        hit;
	logic [IW-1:0]           enc_pos;
	logic                    enc_found;

	logic                    full;
	logic                    go;
	logic [1:0]              nxt_status;
	logic [IW-1:0]           nxt_pos;
	logic [CW-1:0]           nxt_cnt;
	logic [PW-1:0]           pos_wide;
	logic [NW-1:0]           cnt_wide;

	// Chain of cells; each reads its left neighbor's flags and both neighbors' values.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    p_le;
		logic                    p_lt;
		logic signed [KEY_W-1:0] p_val;
		logic signed [KEY_W-1:0] n_val;

		assign cell_valid[i] = CW'(i) < cnt_q;

		if (i == 0) begin : g_first
			assign p_le  = 1'b1;
			assign p_lt  = 1'b1;
			assign p_val = key_q;
		end else begin : g_mid
			assign p_le  = cell_le[i-1];
			assign p_lt  = cell_lt[i-1];
			assign p_val = cell_val[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign n_val = key_q;
		end else begin : g_inner
			assign n_val = cell_val[i+1];
		end

		sortab_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.key      (key_q),
			.valid    (cell_valid[i]),
			.prev_le  (p_le),
			.prev_lt  (p_lt),
			.prev_val (p_val),
			.next_val (n_val),
			.val      (cell_val[i]),
			.le       (cell_le[i]),
			.lt       (cell_lt[i]),
			.ins_hit  (ins_hit[i]),
			.del_hit  (del_hit[i])
		);
	end

	// Insert looks for its slot; delete and search look for the first equal cell.
	assign hit = (cmd_q == CMD_INSERT) ? ins_hit : del_hit;

	sortab_enc #(
		.DEPTH (DEPTH)
	) u_enc (
		.clk   (clk),
		.hit   (hit),
		.pos   (enc_pos),
		.found (enc_found)
	);

	assign full = cnt_q == CW'(DEPTH);
	assign go   = !res_valid_q || !res_stall;

	// Strobes to the cells.
	always_comb begin
		ctrl.cmp = state_q == S_CMP;
		ctrl.ins = (state_q == S_UPD) && go && (cmd_q == CMD_INSERT) && !full;
		ctrl.del = (state_q == S_UPD) && go && (cmd_q == CMD_DELETE) && enc_found;
	end

	// Result and new count for the request in its update step.
	always_comb begin
		nxt_status = STAT_NOT_FOUND;
		nxt_pos    = '0;
		nxt_cnt    = cnt_q;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (full) begin
					nxt_status = STAT_FULL;
				end else begin
					nxt_status = STAT_DONE;
					nxt_pos    = enc_pos;
					nxt_cnt    = cnt_q + CW'(1);
				end
			end
			CMD_DELETE: begin
				if (enc_found) begin
					nxt_status = STAT_DONE;
					nxt_pos    = enc_pos;
					nxt_cnt    = cnt_q - CW'(1);
				end
			end
			CMD_SEARCH: begin
				if (enc_found) begin
					nxt_status = STAT_DONE;
					nxt_pos    = enc_pos;
				end
			end
			default: begin
				nxt_status = STAT_NOT_FOUND;
			end
		endcase
	end

	assign pos_wide = PW'(nxt_pos);
	assign cnt_wide = NW'(nxt_cnt);

	// Sequencer, count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			key_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			status_q    <= '0;
			position_q  <= '0;
			held_q      <= '0;
		end else begin
			// The result register fills from the update step and empties when taken.
			if (state_q == S_UPD && go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= command;
						key_q   <= value;
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_ENC1;
				end
				S_ENC1: begin
					state_q <= S_ENC2;
				end
				S_ENC2: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (go) begin
						status_q    <= nxt_status;
						position_q  <= pos_wide[6:0];
						held_q      <= cnt_wide[6:0];
						cnt_q       <= nxt_cnt;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall    = state_q != S_IDLE;
	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign position     = position_q;
	assign entries_held = held_q;

`ifndef SYNTHESIS
	// The count never passes the table depth.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// At most one cell flags the slot or the first match.
	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ENC1 |-> $onehot0(hit))
		else $error("more than one cell flagged");

	// An insert into a table with room always finds its slot.
	a_ins_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && cmd_q == CMD_INSERT && !full) |-> enc_found)
		else $error("insert slot not found");

	// A new result only appears out of the update step.
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_UPD))
		else $error("result loaded outside update step");
`endif

endmodule
